@@ hdl/hc29_pkg.sv @@
// ----------------------------------------------------------------------------
// hc29_pkg: shared types, constants and functions
// Symbol alphabet mapping, mod-29 reduction and the pair record passed
// between the pairing stage and the mix stage.
// ----------------------------------------------------------------------------
package hc29_pkg;

    localparam int unsigned CharW = 8;
    localparam int unsigned SymW  = 5;
    localparam int unsigned KeyW  = 5;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned SumW  = 11;   // 2 * 31 * 28 fits in 11 bits

    localparam logic [SymW-1:0] AlphabetSize = 5'd29;
    localparam logic [SymW-1:0] SymSpace  = 5'd26;
    localparam logic [SymW-1:0] SymPeriod = 5'd27;
    localparam logic [SymW-1:0] SymComma  = 5'd28;

    localparam logic [CharW-1:0] CharBase   = 8'd97;
    localparam logic [CharW-1:0] CharEnd    = 8'd123;
    localparam logic [CharW-1:0] CharSpace  = 8'd32;
    localparam logic [CharW-1:0] CharPeriod = 8'd46;
    localparam logic [CharW-1:0] CharComma  = 8'd44;

    // Reciprocal of 29 scaled by 2^14; exact quotient for sums below 2^14.
    localparam int unsigned RecipShift = 14;
    localparam logic [9:0]  Recip29    = 10'd565;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CfgKeyR0C0 = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgKeyR0C1 = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgKeyR1C0 = 2'd2;
    localparam logic [CfgIdxW-1:0] CfgKeyR1C1 = 2'd3;

    localparam logic [KeyW-1:0] KeyR0C0Rst = 5'd2;
    localparam logic [KeyW-1:0] KeyR0C1Rst = 5'd3;
    localparam logic [KeyW-1:0] KeyR1C0Rst = 5'd5;
    localparam logic [KeyW-1:0] KeyR1C1Rst = 5'd7;

    typedef struct packed {
        logic            valid;
        logic [SymW-1:0] p0;
        logic [SymW-1:0] p1;
        logic            bad;
        logic            last;
    } t_pair;

    typedef struct packed {
        logic [KeyW-1:0] r0c0;
        logic [KeyW-1:0] r0c1;
        logic [KeyW-1:0] r1c0;
        logic [KeyW-1:0] r1c1;
    } t_key;

    // Byte to symbol; bit SymW flags a byte outside the alphabet.
    function automatic logic [SymW:0] sym_of_byte(input logic [CharW-1:0] b);
        logic [CharW-1:0] diff;
        diff = b - CharBase;
        if (b == CharSpace) begin
            sym_of_byte = {1'b0, SymSpace};
        end else if (b == CharPeriod) begin
            sym_of_byte = {1'b0, SymPeriod};
        end else if (b == CharComma) begin
            sym_of_byte = {1'b0, SymComma};
        end else if (b >= CharBase && b < CharEnd) begin
            sym_of_byte = {1'b0, diff[SymW-1:0]};
        end else begin
            sym_of_byte = {1'b1, SymSpace};
        end
    endfunction

    function automatic logic [CharW-1:0] byte_of_sym(input logic [SymW-1:0] s);
        if (s == SymSpace) begin
            byte_of_sym = CharSpace;
        end else if (s == SymPeriod) begin
            byte_of_sym = CharPeriod;
        end else if (s == SymComma) begin
            byte_of_sym = CharComma;
        end else begin
            byte_of_sym = {3'b000, s} + CharBase;
        end
    endfunction

    // x mod 29 by reciprocal multiply; the 6-bit quotient is exact for x < 1856.
    function automatic logic [SymW-1:0] mod29(input logic [SumW-1:0] x);
        logic [SumW+9:0] prod;
        logic [5:0]      q;
        logic [SumW-1:0] qm;
        logic [SumW-1:0] r;
        prod = {10'd0, x} * {{SumW{1'b0}}, Recip29};
        q    = prod[RecipShift+5:RecipShift];
        qm   = {5'd0, q} * {6'd0, AlphabetSize};
        r    = x - qm;
        mod29 = r[SymW-1:0];
    endfunction

endpackage

@@ hdl/hill_cipher_2x2_mod29_unit.sv @@
// ----------------------------------------------------------------------------
// hill_cipher_2x2_mod29_unit: 2x2 Hill cipher over a 29-symbol alphabet
// Enciphers a byte stream pair by pair with a configurable key matrix.
// ----------------------------------------------------------------------------
// Takes one text byte per input transaction (a-z, space, period, comma) and
// enciphers symbol pairs with the 2x2 key held in the four key registers,
// modulo 29. Every second byte, or a byte marked last that opens a pair
// (padded with a space), produces two output transactions; a byte outside
// the alphabet is enciphered as a space and o_bad_symbol marks both bytes
// of its pair. With the output ready, a byte is accepted every cycle and
// two bytes leave for every two bytes taken, so ordinary text flows at one
// byte per cycle; a padded last byte yields two output bytes from one input
// byte. The input stalls whenever the pairing register holds a pair that
// the result register cannot take, even for a byte that only opens a pair.
// Accepting the second byte of a pair loads the pairing register; the
// result register takes the pair from there once it is free, and the
// first enciphered byte is then offered on the output port.
// Write keys only while the unit is idle.
// ----------------------------------------------------------------------------
module hill_cipher_2x2_mod29_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [hc29_pkg::CharW-1:0]    i_in_char,
    input  logic                          i_in_last,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [hc29_pkg::CharW-1:0]    o_out_char,
    output logic                          o_out_last,
    output logic                          o_bad_symbol,
    input  logic                          i_cfg_we,
    input  logic [hc29_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [hc29_pkg::KeyW-1:0]     i_cfg_data
);
    import hc29_pkg::*;

    t_key  r_key;
    t_pair w_pair;
    logic  w_load;
    logic  w_fire;

    // Key registers: written directly, no read-back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key.r0c0 <= KeyR0C0Rst;
            r_key.r0c1 <= KeyR0C1Rst;
            r_key.r1c0 <= KeyR1C0Rst;
            r_key.r1c1 <= KeyR1C1Rst;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CfgKeyR0C0: r_key.r0c0 <= i_cfg_data;
                CfgKeyR0C1: r_key.r0c1 <= i_cfg_data;
                CfgKeyR1C0: r_key.r1c0 <= i_cfg_data;
                CfgKeyR1C1: r_key.r1c1 <= i_cfg_data;
                default:    r_key      <= r_key;
            endcase
        end
    end

    // Accept whenever the pair register is free or drains this cycle
    assign o_in_ready = ~w_pair.valid | w_load;
    assign w_fire     = i_in_valid & o_in_ready;

    hc29_pair u_pair (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_char  (i_in_char),
        .i_last  (i_in_last),
        .i_take  (w_load),
        .o_pair  (w_pair)
    );

    hc29_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pair  (w_pair),
        .i_key   (r_key),
        .i_ready (i_out_ready),
        .o_load  (w_load),
        .o_valid (o_out_valid),
        .o_char  (o_out_char),
        .o_last  (o_out_last),
        .o_bad   (o_bad_symbol)
    );

endmodule

@@ hdl/hc29_pair.sv @@
// ----------------------------------------------------------------------------
// hc29_pair: symbol mapping and pair assembly
// Maps each accepted byte to a symbol, holds the first of a pair and
// registers a complete pair (padded with a space on a lone last byte).
// ----------------------------------------------------------------------------
module hc29_pair (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic [hc29_pkg::CharW-1:0]  i_char,
    input  logic                        i_last,
    input  logic                        i_take,
    output hc29_pkg::t_pair             o_pair
);
    import hc29_pkg::*;

    logic [SymW:0]   w_map;
    logic [SymW-1:0] r_held_sym, n_held_sym;
    logic            r_have_first, n_have_first;
    logic            r_held_bad, n_held_bad;
    t_pair           r_pair, n_pair;

    assign w_map = sym_of_byte(i_char);

    always_comb begin
        n_held_sym   = r_held_sym;
        n_have_first = r_have_first;
        n_held_bad   = r_held_bad;
        n_pair       = r_pair;
        if (i_take) begin
            n_pair.valid = 1'b0;
        end
        if (i_fire) begin
            if (r_have_first) begin
                n_pair.valid = 1'b1;
                n_pair.p0    = r_held_sym;
                n_pair.p1    = w_map[SymW-1:0];
                n_pair.bad   = r_held_bad | w_map[SymW];
                n_pair.last  = i_last;
                n_have_first = 1'b0;
                n_held_bad   = 1'b0;
            end else if (i_last) begin
                n_pair.valid = 1'b1;
                n_pair.p0    = w_map[SymW-1:0];
                n_pair.p1    = SymSpace;
                n_pair.bad   = w_map[SymW];
                n_pair.last  = 1'b1;
            end else begin
                n_held_sym   = w_map[SymW-1:0];
                n_held_bad   = w_map[SymW];
                n_have_first = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_held_sym  <= n_held_sym;
        r_pair.p0   <= n_pair.p0;
        r_pair.p1   <= n_pair.p1;
        r_pair.bad  <= n_pair.bad;
        r_pair.last <= n_pair.last;
        if (!i_rst_n) begin
            r_have_first <= 1'b0;
            r_held_bad   <= 1'b0;
            r_pair.valid <= 1'b0;
        end else begin
            r_have_first <= n_have_first;
            r_held_bad   <= n_held_bad;
            r_pair.valid <= n_pair.valid;
        end
    end

    assign o_pair = r_pair;

endmodule

@@ hdl/hc29_mix.sv @@
// ----------------------------------------------------------------------------
// hc29_mix: key matrix multiply and result serializer
// Multiplies a pair by the key mod 29, registers both bytes and sends
// them out one transaction at a time.
// ----------------------------------------------------------------------------
module hc29_mix (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  hc29_pkg::t_pair             i_pair,
    input  hc29_pkg::t_key              i_key,
    input  logic                        i_ready,
    output logic                        o_load,
    output logic                        o_valid,
    output logic [hc29_pkg::CharW-1:0]  o_char,
    output logic                        o_last,
    output logic                        o_bad
);
    import hc29_pkg::*;

    logic [SumW-1:0]  w_sum0, w_sum1;
    logic [CharW-1:0] r_c0, r_c1;
    logic             r_last, r_bad;
    logic             r_valid, n_valid;
    logic             r_sel, n_sel;
    logic             w_done;

    assign w_sum0 = SumW'({5'd0, i_key.r0c0} * {5'd0, i_pair.p0})
                  + SumW'({5'd0, i_key.r0c1} * {5'd0, i_pair.p1});
    assign w_sum1 = SumW'({5'd0, i_key.r1c0} * {5'd0, i_pair.p0})
                  + SumW'({5'd0, i_key.r1c1} * {5'd0, i_pair.p1});

    // second byte leaves this cycle: buffer frees up
    assign w_done = r_valid & r_sel & i_ready;
    assign o_load = i_pair.valid & (~r_valid | w_done);

    always_comb begin
        n_valid = r_valid;
        n_sel   = r_sel;
        if (r_valid && i_ready) begin
            n_sel = ~r_sel;
            if (r_sel) begin
                n_valid = 1'b0;
            end
        end
        if (o_load) begin
            n_valid = 1'b1;
            n_sel   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load) begin
            r_c0   <= byte_of_sym(mod29(w_sum0));
            r_c1   <= byte_of_sym(mod29(w_sum1));
            r_last <= i_pair.last;
            r_bad  <= i_pair.bad;
        end
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_sel   <= n_sel;
        end
    end

    assign o_valid = r_valid;
    assign o_char  = r_sel ? r_c1 : r_c0;
    assign o_last  = r_sel & r_last;
    assign o_bad   = r_bad;

endmodule

@@ hdl/hc29_checker.sv @@
// ----------------------------------------------------------------------------
// hc29_checker: port-level checks for the cipher unit
// Watches the top-level ports; attached to every instance by bind.
// ----------------------------------------------------------------------------
module hc29_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_out_valid,
    input logic                          i_out_ready,
    input logic [hc29_pkg::CharW-1:0]    o_out_char,
    input logic                          o_out_last,
    input logic                          o_bad_symbol
);
    import hc29_pkg::*;

    // nothing leaves the unit right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // a stalled transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_char)
            && $stable(o_out_last) && $stable(o_bad_symbol))
        else $error("stalled output changed");

    // every enciphered byte lies in the alphabet
    a_out_alpha: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_char >= CharBase && o_out_char < CharEnd)
            || o_out_char == CharSpace || o_out_char == CharPeriod
            || o_out_char == CharComma)
        else $error("output byte outside alphabet");

endmodule

bind hill_cipher_2x2_mod29_unit hc29_checker u_hc29_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_out_char   (o_out_char),
    .o_out_last   (o_out_last),
    .o_bad_symbol (o_bad_symbol)
);
